@@ sv/bmp_pkg.sv @@
package bmp_pkg;

  // input item as it arrives on the byte stream
  typedef struct packed {
    logic [7:0] file_byte;
    logic       first_byte;
  } in_item_t;

  // result item: pixel, header acceptance or error report
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [11:0] column;
    logic [11:0] row;
    logic        last_pixel;
    logic [2:0]  error_code;
    logic [12:0] image_width;
    logic [12:0] image_height;
  } out_item_t;

  // parser phases
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEADER,
    PH_SKIP,
    PH_PIXELS,
    PH_DONE,
    PH_ERROR
  } phase_t;

  // result kinds
  typedef enum logic [1:0] {
    KIND_PIXEL  = 2'd0,
    KIND_HEADER = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  // error codes
  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_SIG      = 3'd1,
    ERR_UNSUP    = 3'd2,
    ERR_UNKNOWN  = 3'd3,
    ERR_BPP      = 3'd4,
    ERR_COMPRESS = 3'd5,
    ERR_OFFSET   = 3'd6,
    ERR_SIZE     = 3'd7
  } err_t;

  // signature bytes
  localparam logic [7:0] CHR_B = 8'h42;
  localparam logic [7:0] CHR_M = 8'h4D;

  // header lengths
  localparam logic [31:0] HLEN_INFO = 32'd40;
  localparam logic [31:0] HLEN_CORE = 32'd12;
  localparam logic [31:0] HLEN_V3   = 32'd64;
  localparam logic [31:0] HLEN_V4   = 32'd108;
  localparam logic [31:0] HLEN_V5   = 32'd124;

  localparam logic [15:0] BPP_24 = 16'd24;

  // byte positions inside the header
  localparam logic [31:0] POS_SIG0      = 32'd0;
  localparam logic [31:0] POS_SIG1      = 32'd1;
  localparam logic [31:0] POS_OFFSET    = 32'd13;
  localparam logic [31:0] POS_HLEN      = 32'd17;
  localparam logic [31:0] POS_CORE_W    = 32'd19;
  localparam logic [31:0] POS_CORE_H    = 32'd21;
  localparam logic [31:0] POS_CORE_BPP  = 32'd25;
  localparam logic [31:0] POS_INFO_W    = 32'd21;
  localparam logic [31:0] POS_INFO_H    = 32'd25;
  localparam logic [31:0] POS_INFO_BPP  = 32'd29;
  localparam logic [31:0] POS_INFO_COMP = 32'd31;
  localparam logic [31:0] HEND_INFO     = 32'd32;
  localparam logic [31:0] HEND_CORE     = 32'd26;

  // dimension is zero, negative or above its limit
  function automatic logic dim_bad(input logic [31:0] v, input logic [31:0] lim);
    dim_bad = v[31] || (v == 32'd0) || (v > lim);
  endfunction

endpackage

@@ sv/bmp_parse.sv @@
module bmp_parse #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_fire,
  input  bmp_pkg::in_item_t   in_item,
  output logic                res_vld,
  output bmp_pkg::out_item_t  res
);

  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int RBW = WW + 2;

  bmp_pkg::phase_t phase_r, phase_nxt, ph_eff;

  logic [31:0]    pos_r, pos_nxt, pos_eff, pos_inc;
  logic [31:0]    wa_r, word;
  logic [31:0]    offset_r, offset_nxt;
  logic           is40_r, is40_nxt;
  logic [WW-1:0]  width_r, width_nxt;
  logic [HW-1:0]  height_r, height_nxt;
  logic           wbad_r, wbad_nxt, hbad_r, hbad_nxt;
  logic [RBW-1:0] rowbytes_r, rowbytes_nxt, stride_r, stride_nxt;
  logic [RBW-1:0] rb_r, rb_nxt, rb_inc, rowbytes_c, stride_c;
  logic [1:0]     ch_r, ch_nxt;
  logic [WW-1:0]  col_r, col_nxt;
  logic [HW-1:0]  row_r, row_nxt;
  logic [7:0]     blue_r, blue_nxt, green_r, green_nxt;

  logic [7:0]     b;
  logic [31:0]    dim_word, hend;
  logic           dim_is_bad;
  logic           hdr, skp, pix;
  logic           hdr_fin, hdr_acc, hdr_bad;
  bmp_pkg::err_t  hdr_err;
  logic           in_data, emit, last, row_end, skip_end;
  logic           w_cap, h_cap;

  // effective phase and position, first byte restarts the parser
  assign b        = in_item.file_byte;
  assign ph_eff   = in_item.first_byte ? bmp_pkg::PH_HEADER : phase_r;
  assign pos_eff  = in_item.first_byte ? 32'd0 : pos_r;
  assign pos_inc  = pos_eff + 32'd1;
  assign word     = {b, wa_r[31:8]};
  assign hdr      = in_fire && (ph_eff == bmp_pkg::PH_HEADER);
  assign skp      = in_fire && (ph_eff == bmp_pkg::PH_SKIP);
  assign pix      = in_fire && (ph_eff == bmp_pkg::PH_PIXELS);
  assign hend     = is40_r ? bmp_pkg::HEND_INFO : bmp_pkg::HEND_CORE;
  assign skip_end = pos_inc >= offset_r;

  // dimension capture, core header carries signed 16-bit fields
  assign dim_word   = is40_r ? word : {{16{word[31]}}, word[31:16]};
  assign w_cap      = (pos_eff > bmp_pkg::POS_HLEN) &&
                      (is40_r ? (pos_eff == bmp_pkg::POS_INFO_W)
                              : (pos_eff == bmp_pkg::POS_CORE_W));
  assign h_cap      = (pos_eff > bmp_pkg::POS_HLEN) &&
                      (is40_r ? (pos_eff == bmp_pkg::POS_INFO_H)
                              : (pos_eff == bmp_pkg::POS_CORE_H));
  assign dim_is_bad = 1'b0;

  // header checks in priority order
  always_comb begin
    hdr_err = bmp_pkg::ERR_NONE;
    hdr_fin = 1'b0;
    if (pos_eff == bmp_pkg::POS_SIG0) begin
      if (b != bmp_pkg::CHR_B) hdr_err = bmp_pkg::ERR_SIG;
    end else if (pos_eff == bmp_pkg::POS_SIG1) begin
      if (b != bmp_pkg::CHR_M) hdr_err = bmp_pkg::ERR_SIG;
    end else if (pos_eff == bmp_pkg::POS_HLEN) begin
      if (word == bmp_pkg::HLEN_V3 || word == bmp_pkg::HLEN_V4 ||
          word == bmp_pkg::HLEN_V5) begin
        hdr_err = bmp_pkg::ERR_UNSUP;
      end else if (word != bmp_pkg::HLEN_INFO && word != bmp_pkg::HLEN_CORE) begin
        hdr_err = bmp_pkg::ERR_UNKNOWN;
      end
    end else if (is40_r) begin
      if (pos_eff == bmp_pkg::POS_INFO_BPP) begin
        if (word[31:16] != bmp_pkg::BPP_24) hdr_err = bmp_pkg::ERR_BPP;
      end else if (pos_eff == bmp_pkg::POS_INFO_COMP) begin
        if (word[31:16] != 16'd0) hdr_err = bmp_pkg::ERR_COMPRESS;
        else hdr_fin = 1'b1;
      end
    end else begin
      if (pos_eff == bmp_pkg::POS_CORE_BPP) begin
        if (word[31:16] != bmp_pkg::BPP_24) hdr_err = bmp_pkg::ERR_BPP;
        else hdr_fin = 1'b1;
      end
    end
    // end of header: size first, then offset
    if (hdr_fin) begin
      if (wbad_r || hbad_r) begin
        hdr_err = bmp_pkg::ERR_SIZE;
      end else if (offset_r[31] || (offset_r < hend)) begin
        hdr_err = bmp_pkg::ERR_OFFSET;
      end
    end
  end

  assign hdr_bad = hdr && (hdr_err != bmp_pkg::ERR_NONE);
  assign hdr_acc = hdr && hdr_fin && (hdr_err == bmp_pkg::ERR_NONE);

  // row geometry, stride is row bytes rounded up to four
  assign rowbytes_c = RBW'({width_r, 1'b0}) + RBW'(width_r);
  assign stride_c   = (rowbytes_c + RBW'(3)) & ~RBW'(3);

  // pixel byte decode
  assign in_data = rb_r < rowbytes_r;
  assign rb_inc  = rb_r + RBW'(1);
  assign row_end = rb_inc == stride_r;
  assign emit    = pix && in_data && (ch_r == 2'd2);
  assign last    = emit && (({1'b0, col_r} + 1'b1) == {1'b0, width_r}) &&
                   (({1'b0, row_r} + 1'b1) == {1'b0, height_r});

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (in_fire) begin
      unique case (ph_eff)
        bmp_pkg::PH_HEADER: begin
          if (hdr_bad) phase_nxt = bmp_pkg::PH_ERROR;
          else if (hdr_acc) begin
            phase_nxt = (offset_r == hend) ? bmp_pkg::PH_PIXELS : bmp_pkg::PH_SKIP;
          end else phase_nxt = bmp_pkg::PH_HEADER;
        end
        bmp_pkg::PH_SKIP:   phase_nxt = skip_end ? bmp_pkg::PH_PIXELS : bmp_pkg::PH_SKIP;
        bmp_pkg::PH_PIXELS: phase_nxt = last ? bmp_pkg::PH_DONE : bmp_pkg::PH_PIXELS;
        default:            phase_nxt = phase_r;
      endcase
    end
  end

  // datapath next values
  always_comb begin
    pos_nxt      = pos_r;
    offset_nxt   = offset_r;
    is40_nxt     = is40_r;
    width_nxt    = width_r;
    height_nxt   = height_r;
    wbad_nxt     = wbad_r;
    hbad_nxt     = hbad_r;
    rowbytes_nxt = rowbytes_r;
    stride_nxt   = stride_r;
    rb_nxt       = rb_r;
    ch_nxt       = ch_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    blue_nxt     = blue_r;
    green_nxt    = green_r;
    if (hdr) begin
      pos_nxt = hdr_acc ? hend : pos_inc;
      if (pos_eff == bmp_pkg::POS_OFFSET) offset_nxt = word;
      if (pos_eff == bmp_pkg::POS_HLEN) is40_nxt = (word == bmp_pkg::HLEN_INFO);
      if (w_cap) begin
        width_nxt = WW'(dim_word);
        wbad_nxt  = bmp_pkg::dim_bad(dim_word, 32'(MAX_WIDTH));
      end
      if (h_cap) begin
        height_nxt = HW'(dim_word);
        hbad_nxt   = bmp_pkg::dim_bad(dim_word, 32'(MAX_HEIGHT));
      end
      if (hdr_acc) begin
        rowbytes_nxt = rowbytes_c;
        stride_nxt   = stride_c;
        rb_nxt       = '0;
        ch_nxt       = 2'd0;
        col_nxt      = '0;
        row_nxt      = '0;
      end
    end
    if (skp) pos_nxt = pos_inc;
    if (pix) begin
      if (in_data) begin
        case (ch_r)
          2'd0:    blue_nxt  = b;
          2'd1:    green_nxt = b;
          default: col_nxt   = col_r + WW'(1);
        endcase
        ch_nxt = (ch_r == 2'd2) ? 2'd0 : ch_r + 2'd1;
      end
      rb_nxt = rb_inc;
      if (row_end) begin
        rb_nxt  = '0;
        ch_nxt  = 2'd0;
        col_nxt = '0;
        row_nxt = row_r + HW'(1);
      end
    end
  end

  // result item
  always_comb begin
    res     = '0;
    res_vld = hdr_bad || hdr_acc || emit;
    if (hdr_bad) begin
      res.kind       = bmp_pkg::KIND_ERROR;
      res.error_code = hdr_err;
    end else if (hdr_acc) begin
      res.kind         = bmp_pkg::KIND_HEADER;
      res.image_width  = 13'(width_r);
      res.image_height = 13'(height_r);
    end else if (emit) begin
      res.kind         = bmp_pkg::KIND_PIXEL;
      res.red          = b;
      res.green        = green_r;
      res.blue         = blue_r;
      res.column       = 12'(col_r);
      res.row          = 12'(row_r);
      res.last_pixel   = last;
      res.image_width  = 13'(width_r);
      res.image_height = 13'(height_r);
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= bmp_pkg::PH_IDLE;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) wa_r <= word;
    pos_r      <= pos_nxt;
    offset_r   <= offset_nxt;
    is40_r     <= is40_nxt;
    width_r    <= width_nxt;
    height_r   <= height_nxt;
    wbad_r     <= wbad_nxt || dim_is_bad;
    hbad_r     <= hbad_nxt;
    rowbytes_r <= rowbytes_nxt;
    stride_r   <= stride_nxt;
    rb_r       <= rb_nxt;
    ch_r       <= ch_nxt;
    col_r      <= col_nxt;
    row_r      <= row_nxt;
    blue_r     <= blue_nxt;
    green_r    <= green_nxt;
  end

`ifndef ASSERT_OFF
  // the final pixel closes the image
  a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld && res.last_pixel |=> phase_r == bmp_pkg::PH_DONE)
    else $error("phase not done after last pixel");

  // an error report parks the parser
  a_err_park: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld && (res.kind == bmp_pkg::KIND_ERROR) |=> phase_r == bmp_pkg::PH_ERROR)
    else $error("phase not error after error item");

  // pixels only come out while walking pixel data
  a_pix_phase: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld && (res.kind == bmp_pkg::KIND_PIXEL) |-> ph_eff == bmp_pkg::PH_PIXELS)
    else $error("pixel item outside pixel phase");
`endif

endmodule

@@ sv/bmp_out_buf.sv @@
module bmp_out_buf (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_vld,
  input  bmp_pkg::out_item_t push_item,
  output logic               skid_full,
  output logic               out_valid,
  input  logic               out_stall,
  output bmp_pkg::out_item_t out_item
);

  logic               out_vld_r, out_vld_nxt;
  logic               skid_vld_r, skid_vld_nxt;
  bmp_pkg::out_item_t out_r, out_nxt;
  bmp_pkg::out_item_t skid_r, skid_nxt;
  logic               out_free;

  // output slot frees when empty or taken this cycle
  assign out_free = !out_vld_r || !out_stall;

  // two-entry buffer: output register plus skid register
  always_comb begin
    out_vld_nxt  = out_vld_r;
    skid_vld_nxt = skid_vld_r;
    out_nxt      = out_r;
    skid_nxt     = skid_r;
    if (out_free) begin
      if (skid_vld_r) begin
        out_vld_nxt  = 1'b1;
        out_nxt      = skid_r;
        skid_vld_nxt = 1'b0;
      end else begin
        out_vld_nxt = push_vld;
        out_nxt     = push_item;
      end
    end else if (push_vld) begin
      skid_vld_nxt = 1'b1;
      skid_nxt     = push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign skid_full = skid_vld_r;
  assign out_valid = out_vld_r;
  assign out_item  = out_r;

`ifndef ASSERT_OFF
  // skid holds an item only behind a full output register
  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid full with empty output");

  // no new item while the skid is occupied
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    push_vld |-> !skid_vld_r)
    else $error("item pushed into full buffer");

  // a stalled output with a waiting item keeps both
  a_hold_two: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_stall && skid_vld_r |=> out_vld_r && skid_vld_r)
    else $error("buffered item dropped under stall");
`endif

endmodule

@@ sv/bmp_rgb24_stream_decoder.sv @@
// a result is registered in the output register, or in the skid register under stall
// one file byte per cycle while the skid register is free
// a two-entry output buffer lets bytes keep flowing while one result waits
// reset (rst_n low, synchronous) parks the parser waiting for a first byte
// and empties the output buffer
module bmp_rgb24_stream_decoder #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  bmp_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output bmp_pkg::out_item_t out_item
);

  logic               in_fire;
  logic               res_vld;
  logic               skid_full;
  bmp_pkg::out_item_t res;

  // take a byte whenever the skid register is free
  assign in_stall = skid_full;
  assign in_fire  = in_valid && !in_stall;

  bmp_parse #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_item (in_item),
    .res_vld (res_vld),
    .res     (res)
  );

  bmp_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_vld  (res_vld),
    .push_item (res),
    .skid_full (skid_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

@@ tb/tb_bmp_rgb24_stream_decoder.sv @@
module tb_bmp_rgb24_stream_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  import bmp_pkg::*;

  localparam logic [31:0] WIDTH_LIMIT  = 32'd4096;
  localparam logic [31:0] HEIGHT_LIMIT = 32'd4096;
  localparam int HOLD_CYCLES   = 200;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 500000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  bmp_rgb24_stream_decoder #(
    .MAX_WIDTH (4096),
    .MAX_HEIGHT(4096)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  // idling knobs, percent per cycle
  int send_idle_pct;
  int recv_stall_pct;
  int hold_requests;
  int holds_taken;
  int hold_left;

  int cycle_count;
  int mismatch_count;

  out_item_t  pending_results[$];
  logic [7:0] file_bytes[$];

  // decoder state as predicted
  phase_t      dec_phase;
  logic [31:0] dec_pos;
  logic [31:0] dec_word;
  logic [31:0] dec_offset;
  logic [31:0] dec_hlen;
  logic [31:0] dec_width;
  logic [31:0] dec_height;
  logic [31:0] dec_row_bytes;
  logic [31:0] dec_col;
  logic [31:0] dec_row;
  logic [7:0]  dec_blue;
  logic [7:0]  dec_green;

  function automatic void decoder_clear();
    dec_phase     = PH_IDLE;
    dec_pos       = '0;
    dec_word      = '0;
    dec_offset    = '0;
    dec_hlen      = '0;
    dec_width     = '0;
    dec_height    = '0;
    dec_row_bytes = '0;
    dec_col       = '0;
    dec_row       = '0;
    dec_blue      = '0;
    dec_green     = '0;
  endfunction

  function automatic out_item_t error_result(input err_t code);
    out_item_t r;
    r            = '0;
    r.kind       = KIND_ERROR;
    r.error_code = code;
    dec_phase    = PH_ERROR;
    return r;
  endfunction

  // size and offset checks once the header is complete
  function automatic bit header_end(input logic [31:0] hend, output out_item_t r);
    bit bad_w;
    bit bad_h;
    r     = '0;
    bad_w = dec_width[31] || (dec_width == 0) || (dec_width > WIDTH_LIMIT);
    bad_h = dec_height[31] || (dec_height == 0) || (dec_height > HEIGHT_LIMIT);
    if (bad_w || bad_h) begin
      r = error_result(ERR_SIZE);
      return 1'b1;
    end
    if (dec_offset[31] || dec_offset < hend) begin
      r = error_result(ERR_OFFSET);
      return 1'b1;
    end
    dec_pos        = hend;
    dec_row_bytes  = '0;
    dec_col        = '0;
    dec_row        = '0;
    dec_phase      = (dec_offset == hend) ? PH_PIXELS : PH_SKIP;
    r.kind         = KIND_HEADER;
    r.image_width  = dec_width[12:0];
    r.image_height = dec_height[12:0];
    return 1'b1;
  endfunction

  function automatic bit header_step(input logic [7:0] b, output out_item_t r);
    logic [31:0] p;
    r        = '0;
    p        = dec_pos;
    dec_word = {b, dec_word[31:8]};
    dec_pos  = p + 1;
    if ((p == POS_SIG0 && b != CHR_B) || (p == POS_SIG1 && b != CHR_M)) begin
      r = error_result(ERR_SIG);
      return 1'b1;
    end
    if (p == POS_OFFSET) dec_offset = dec_word;
    if (p == POS_HLEN) begin
      dec_hlen = dec_word;
      if (dec_hlen == HLEN_V3 || dec_hlen == HLEN_V4 || dec_hlen == HLEN_V5) begin
        r = error_result(ERR_UNSUP);
        return 1'b1;
      end
      if (dec_hlen != HLEN_INFO && dec_hlen != HLEN_CORE) begin
        r = error_result(ERR_UNKNOWN);
        return 1'b1;
      end
    end
    if (p <= POS_HLEN) return 1'b0;
    if (dec_hlen == HLEN_INFO) begin
      if (p == POS_INFO_W) begin
        dec_width = dec_word;
      end else if (p == POS_INFO_H) begin
        dec_height = dec_word;
      end else if (p == POS_INFO_BPP) begin
        if (dec_word[31:16] != BPP_24) begin
          r = error_result(ERR_BPP);
          return 1'b1;
        end
      end else if (p == POS_INFO_COMP) begin
        if (dec_word[31:16] != 16'd0) begin
          r = error_result(ERR_COMPRESS);
          return 1'b1;
        end
        return header_end(HEND_INFO, r);
      end
    end else begin
      // core header: 16-bit signed dimensions
      if (p == POS_CORE_W) begin
        dec_width = {{16{dec_word[31]}}, dec_word[31:16]};
      end else if (p == POS_CORE_H) begin
        dec_height = {{16{dec_word[31]}}, dec_word[31:16]};
      end else if (p == POS_CORE_BPP) begin
        if (dec_word[31:16] != BPP_24) begin
          r = error_result(ERR_BPP);
          return 1'b1;
        end
        return header_end(HEND_CORE, r);
      end
    end
    return 1'b0;
  endfunction

  // one byte of pixel data: collect b,g then emit on r, drop row padding
  function automatic bit pixel_step(input logic [7:0] b, output out_item_t r);
    logic [31:0] row_len;
    logic [31:0] stride;
    logic [31:0] rb;
    bit          got;
    bit          last;
    r       = '0;
    got     = 1'b0;
    row_len = dec_width * 3;
    stride  = (row_len + 3) & ~32'd3;
    rb      = dec_row_bytes;
    if (rb < row_len) begin
      case (rb % 3)
        0: dec_blue = b;
        1: dec_green = b;
        default: begin
          last           = (dec_col + 1 == dec_width) && (dec_row + 1 == dec_height);
          r.kind         = KIND_PIXEL;
          r.red          = b;
          r.green        = dec_green;
          r.blue         = dec_blue;
          r.column       = dec_col[11:0];
          r.row          = dec_row[11:0];
          r.last_pixel   = last;
          r.image_width  = dec_width[12:0];
          r.image_height = dec_height[12:0];
          got            = 1'b1;
          dec_col        = dec_col + 1;
          if (last) begin
            dec_phase = PH_DONE;
            return 1'b1;
          end
        end
      endcase
    end
    rb = rb + 1;
    if (rb >= stride) begin
      rb      = '0;
      dec_col = '0;
      dec_row = dec_row + 1;
    end
    dec_row_bytes = rb;
    return got;
  endfunction

  function automatic bit decode_byte(input in_item_t it, output out_item_t r);
    r = '0;
    if (it.first_byte) begin
      decoder_clear();
      dec_phase = PH_HEADER;
    end
    case (dec_phase)
      PH_HEADER: return header_step(it.file_byte, r);
      PH_SKIP: begin
        dec_pos = dec_pos + 1;
        if (dec_pos >= dec_offset) dec_phase = PH_PIXELS;
        return 1'b0;
      end
      PH_PIXELS: return pixel_step(it.file_byte, r);
      default: return 1'b0;
    endcase
  endfunction

  // file image builders
  function automatic void push_le(input logic [31:0] v, input int n);
    for (int i = 0; i < n; i++) file_bytes.push_back(v[8*i +: 8]);
  endfunction

  function automatic void push_random(input int n);
    for (int i = 0; i < n; i++) file_bytes.push_back(8'($urandom_range(255)));
  endfunction

  function automatic void build_image(input logic [31:0] hlen, w, h, offset,
                                      input logic [15:0] bpp, comp, input int rows);
    int stride;
    file_bytes.delete();
    file_bytes.push_back(CHR_B);
    file_bytes.push_back(CHR_M);
    push_random(8);
    push_le(offset, 4);
    push_le(hlen, 4);
    if (hlen == HLEN_CORE) begin
      push_le(w, 2);
      push_le(h, 2);
      push_random(2);
      push_le({16'd0, bpp}, 2);
    end else begin
      push_le(w, 4);
      push_le(h, 4);
      push_random(2);
      push_le({16'd0, bpp}, 2);
      push_le({16'd0, comp}, 2);
    end
    // gap up to the pixel data, capped for absurd offsets
    while (file_bytes.size() < offset && file_bytes.size() < 256) push_random(1);
    if (rows > 0) begin
      stride = ((int'(w) * 3 + 3) / 4) * 4;
      for (int r = 0; r < rows; r++) push_random(stride);
    end
  endfunction

  function automatic void cut_file(input int n);
    while (file_bytes.size() > n) void'(file_bytes.pop_back());
  endfunction

  function automatic string show(input out_item_t v);
    return $sformatf("kind %0d rgb %h/%h/%h col %0d row %0d last %0b err %0d size %0dx%0d",
                     v.kind, v.red, v.green, v.blue, v.column, v.row, v.last_pixel,
                     v.error_code, v.image_width, v.image_height);
  endfunction

  function automatic string first_diff(input out_item_t e, input out_item_t a);
    if (a.kind !== e.kind) return "kind";
    if (a.red !== e.red) return "red";
    if (a.green !== e.green) return "green";
    if (a.blue !== e.blue) return "blue";
    if (a.column !== e.column) return "column";
    if (a.row !== e.row) return "row";
    if (a.last_pixel !== e.last_pixel) return "last_pixel";
    if (a.error_code !== e.error_code) return "error_code";
    if (a.image_width !== e.image_width) return "image_width";
    if (a.image_height !== e.image_height) return "image_height";
    return "";
  endfunction

  function automatic void note_mismatch(input string what, input out_item_t want,
                                        input out_item_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch on %s: expected %s, actual %s", what, show(want), show(got));
  endfunction

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // receiver: long hold-off on request, else random stalls
  always @(posedge clk) begin
    if (hold_requests != holds_taken) begin
      holds_taken <= hold_requests;
      hold_left   <= HOLD_CYCLES;
      out_stall   <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    out_item_t want;
    string     diff;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        note_mismatch("result with nothing expected", '0, out_item);
      end else begin
        want = pending_results.pop_front();
        diff = first_diff(want, out_item);
        if (diff != "") note_mismatch(diff, want, out_item);
      end
    end
  end

  // offer one byte, wait for the handshake, then predict its result
  task automatic send_byte(input logic [7:0] b, input logic first);
    in_item_t  it;
    out_item_t r;
    it.file_byte  = b;
    it.first_byte = first;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    if (decode_byte(it, r)) pending_results.push_back(r);
  endtask

  task automatic send_file();
    for (int i = 0; i < file_bytes.size(); i++) send_byte(file_bytes[i], i == 0);
  endtask

  task automatic send_noise(input int n);
    repeat (n) send_byte(8'($urandom_range(255)), 1'b0);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_idling(input int idle_pct, input int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
  endtask

  // stray bytes before any file start
  task automatic test_ignored_before_start();
    send_noise(4);
    send_byte(CHR_B, 1'b0);
    wait_drained();
  endtask

  // bad first and second signature byte
  task automatic test_signature();
    build_image(HLEN_INFO, 32'd2, 32'd2, HEND_INFO, BPP_24, 16'd0, 2);
    file_bytes[0] = CHR_M;
    send_file();
    build_image(HLEN_INFO, 32'd2, 32'd2, HEND_INFO, BPP_24, 16'd0, 2);
    file_bytes[1] = CHR_B;
    send_file();
    wait_drained();
  endtask

  // newer header versions and unknown lengths
  task automatic test_header_lengths();
    logic [31:0] lens[6];
    lens = '{HLEN_V3, HLEN_V4, HLEN_V5, 32'd0, 32'd41, 32'hFFFF_FFFF};
    foreach (lens[i]) begin
      build_image(lens[i], 32'd1, 32'd1, HEND_INFO, BPP_24, 16'd0, 1);
      send_file();
    end
    wait_drained();
  endtask

  // bpp and compression, bpp wins when both are wrong
  task automatic test_format_checks();
    build_image(HLEN_INFO, 32'd2, 32'd1, HEND_INFO, 16'd32, 16'd0, 1);
    send_file();
    build_image(HLEN_INFO, 32'd2, 32'd1, HEND_INFO, BPP_24, 16'd1, 1);
    send_file();
    build_image(HLEN_INFO, 32'd2, 32'd1, HEND_INFO, 16'd8, 16'hFFFF, 1);
    send_file();
    build_image(HLEN_CORE, 32'd2, 32'd1, HEND_CORE, 16'd16, 16'd0, 1);
    send_file();
    wait_drained();
  endtask

  // zero, negative and oversized dimensions, and the largest legal size
  task automatic test_size_limits();
    build_image(HLEN_INFO, 32'd0, 32'd1, HEND_INFO, BPP_24, 16'd0, 0);
    send_file();
    build_image(HLEN_INFO, WIDTH_LIMIT + 1, 32'd1, HEND_INFO, BPP_24, 16'd0, 0);
    send_file();
    build_image(HLEN_INFO, 32'hFFFF_FFFF, 32'd1, HEND_INFO, BPP_24, 16'd0, 0);
    send_file();
    build_image(HLEN_INFO, 32'd1, 32'd0, HEND_INFO, BPP_24, 16'd0, 0);
    send_file();
    build_image(HLEN_INFO, 32'd1, HEIGHT_LIMIT + 1, HEND_INFO, BPP_24, 16'd0, 0);
    send_file();
    build_image(HLEN_INFO, 32'd1, 32'hFFFF_FFFE, HEND_INFO, BPP_24, 16'd0, 0);
    send_file();
    // size beats a bad offset
    build_image(HLEN_INFO, 32'd0, 32'd1, 32'd0, BPP_24, 16'd0, 0);
    send_file();
    build_image(HLEN_CORE, 32'h0000_FFFF, 32'd1, HEND_CORE, BPP_24, 16'd0, 0);
    send_file();
    build_image(HLEN_CORE, 32'd1, 32'h0000_8000, HEND_CORE, BPP_24, 16'd0, 0);
    send_file();
    build_image(HLEN_INFO, WIDTH_LIMIT, HEIGHT_LIMIT, HEND_INFO, BPP_24, 16'd0, 0);
    send_file();
    wait_drained();
  endtask

  // offsets pointing back into the header or negative, and one at the core header end
  task automatic test_offset_checks();
    build_image(HLEN_INFO, 32'd1, 32'd1, HEND_INFO - 1, BPP_24, 16'd0, 1);
    send_file();
    build_image(HLEN_INFO, 32'd1, 32'd1, 32'h8000_0000, BPP_24, 16'd0, 0);
    send_file();
    build_image(HLEN_INFO, 32'd1, 32'd1, 32'd0, BPP_24, 16'd0, 0);
    send_file();
    build_image(HLEN_CORE, 32'd1, 32'd1, HEND_CORE - 1, BPP_24, 16'd0, 1);
    send_file();
    build_image(HLEN_CORE, 32'd1, 32'd1, HEND_CORE, BPP_24, 16'd0, 1);
    send_file();
    wait_drained();
  endtask

  // every padding amount, with and without a gap before the data
  task automatic test_padded_rows();
    for (int w = 1; w <= 4; w++) begin
      build_image(HLEN_INFO, w, 32'd2, (w % 2) ? HEND_INFO : 32'd54, BPP_24, 16'd0, 2);
      send_file();
    end
    wait_drained();
  endtask

  task automatic test_core_images();
    build_image(HLEN_CORE, 32'd3, 32'd2, HEND_CORE, BPP_24, 16'd0, 2);
    send_file();
    build_image(HLEN_CORE, 32'd5, 32'd1, 32'd30, BPP_24, 16'd0, 1);
    send_file();
    wait_drained();
  endtask

  // start of a row at the widest size, then a tall image, both cut short
  task automatic test_widest_row();
    build_image(HLEN_INFO, WIDTH_LIMIT, 32'd1, 32'd54, BPP_24, 16'd0, 1);
    cut_file(96);
    send_file();
    send_noise(3);
    build_image(HLEN_INFO, 32'd1, HEIGHT_LIMIT, HEND_INFO, BPP_24, 16'd0, 3);
    send_file();
    wait_drained();
  endtask

  // restart mid header, mid pixels and after an error, then noise after the last pixel
  task automatic test_restarts();
    build_image(HLEN_INFO, 32'd2, 32'd2, HEND_INFO, BPP_24, 16'd0, 2);
    cut_file(11);
    send_file();
    build_image(HLEN_INFO, 32'd3, 32'd3, 32'd36, BPP_24, 16'd0, 3);
    cut_file(50);
    send_file();
    build_image(HLEN_INFO, 32'd2, 32'd1, HEND_INFO, BPP_24, 16'd0, 1);
    file_bytes[0] = 8'h00;
    send_file();
    send_noise(5);
    build_image(HLEN_CORE, 32'd2, 32'd2, HEND_CORE, BPP_24, 16'd0, 2);
    send_file();
    send_noise(6);
    wait_drained();
  endtask

  // receiver holds off while pixels keep coming, then the sender waits
  task automatic test_back_pressure();
    build_image(HLEN_INFO, 32'd6, 32'd4, HEND_INFO, BPP_24, 16'd0, 4);
    hold_requests++;
    send_file();
    wait_drained();
    build_image(HLEN_CORE, 32'd4, 32'd3, HEND_CORE, BPP_24, 16'd0, 3);
    send_file();
    wait_drained();
  endtask

  // mostly well-formed small files, some corrupted, cut or with odd sizes
  function automatic void random_file();
    logic [31:0] hlen;
    logic [31:0] hend;
    logic [31:0] w;
    logic [31:0] h;
    logic [31:0] offset;
    int          pick;
    pick   = $urandom_range(99);
    hlen   = ($urandom_range(3) == 0) ? HLEN_CORE : HLEN_INFO;
    hend   = (hlen == HLEN_CORE) ? HEND_CORE : HEND_INFO;
    w      = $urandom_range(1, 6);
    h      = $urandom_range(1, 4);
    offset = hend + (($urandom_range(2) == 0) ? $urandom_range(1, 10) : 0);
    build_image(hlen, w, h, offset, BPP_24, 16'd0, h);
    if (pick < 12) begin
      file_bytes[$urandom_range(hend - 1)] = 8'($urandom_range(255));
    end else if (pick < 22) begin
      cut_file($urandom_range(1, file_bytes.size()));
    end else if (pick < 27) begin
      case ($urandom_range(3))
        0: w = 32'd0;
        1: w = 32'hFFFF_FFFF;
        2: w = WIDTH_LIMIT + 1;
        default: w = WIDTH_LIMIT;
      endcase
      build_image(hlen, w, h, offset, BPP_24, 16'd0, 0);
    end
    if ($urandom_range(4) == 0) push_random($urandom_range(1, 6));
  endfunction

  task automatic test_random_files(input int idle_pct, input int stall_pct, input int budget);
    int sent;
    sent = 0;
    set_idling(idle_pct, stall_pct);
    while (sent < budget) begin
      random_file();
      sent += file_bytes.size();
      send_file();
    end
    wait_drained();
  endtask

  // main sequence
  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_item        = '0;
    out_stall      = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_requests  = 0;
    holds_taken    = 0;
    hold_left      = 0;
    cycle_count    = 0;
    mismatch_count = 0;
    decoder_clear();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_ignored_before_start();
    test_signature();
    test_header_lengths();
    test_format_checks();
    test_size_limits();
    test_offset_checks();
    test_padded_rows();
    test_core_images();
    test_widest_row();
    test_restarts();
    test_back_pressure();
    test_random_files(0, 0, 100);
    test_random_files(66, 0, 100);
    test_random_files(0, 66, 100);
    test_random_files(36, 36, 100);

    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
